// ----- design/lpad_pkg.sv -----
// ----------------------------------------------------------------------------
// lpad_pkg
// Types and codes shared by the length-prefixed argument deframer.
// ----------------------------------------------------------------------------
package lpad_pkg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] frame_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  arg_byte;
        logic [11:0] arg_index;
        logic        arg_last;
        logic        frame_done;
        logic [2:0]  status;
    } out_item_t;

    typedef enum logic [1:0] {
        PH_COUNT = 2'd0,
        PH_SIZE  = 2'd1,
        PH_DATA  = 2'd2,
        PH_SKIP  = 2'd3
    } phase_t;

    localparam logic [1:0] KIND_HDR   = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam logic [2:0] ST_BUSY    = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_SHORT   = 3'd2;
    localparam logic [2:0] ST_MANY    = 3'd3;
    localparam logic [2:0] ST_OVERRUN = 3'd4;
    localparam logic [2:0] ST_TRAIL   = 3'd5;

    localparam logic [11:0] MAX_ARGS_RESET = 12'd1024;

endpackage

// ----- design/lpad_in_stage.sv -----
// ----------------------------------------------------------------------------
// lpad_in_stage
// Input register: holds one byte item until the parser takes it.
// ----------------------------------------------------------------------------
module lpad_in_stage
    import lpad_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  in_item_t in_item,
    input  logic     advance,
    output logic     in_stall,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_stall   = valid_reg && !advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ----- design/lpad_parser.sv -----
// ----------------------------------------------------------------------------
// lpad_parser
// Frame state and the per-byte decode of count, size and data fields.
// ----------------------------------------------------------------------------
module lpad_parser
    import lpad_pkg::*;
#(
    parameter int MAX_FRAME = 65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  in_item_t    item,
    input  logic [11:0] max_args,
    output out_item_t   result
);

    localparam logic [23:0] FRAME_CAP = 24'(MAX_FRAME);

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [1:0]  hbc_reg, hbc_next;
    logic [31:0] acc_reg, acc_next;
    logic [11:0] args_rem_reg, args_rem_next;
    logic [15:0] data_rem_reg, data_rem_next;
    logic [11:0] cur_arg_reg, cur_arg_next;
    logic        err_seen_reg, err_seen_next;

    logic [15:0] eff_len;
    logic        last;
    logic [31:0] acc_new;
    logic        full;
    logic [2:0]  err;
    logic [15:0] dr;

    always_comb
    begin
        eff_len = ({8'd0, item.frame_length} > FRAME_CAP) ? FRAME_CAP[15:0]
                                                          : item.frame_length;
        last    = ({1'b0, pos_reg} + 17'd1) >= {1'b0, eff_len};
        acc_new = acc_reg | ({24'd0, item.data_byte} << {hbc_reg, 3'b000});
        full    = (hbc_reg == 2'd3);

        phase_next    = phase_reg;
        pos_next      = pos_reg;
        hbc_next      = hbc_reg;
        acc_next      = acc_reg;
        args_rem_next = args_rem_reg;
        data_rem_next = data_rem_reg;
        cur_arg_next  = cur_arg_reg;
        err_seen_next = err_seen_reg;
        err           = ST_BUSY;
        dr            = data_rem_reg;

        result            = '0;
        result.frame_done = last;

        unique case (phase_reg)
            PH_COUNT:
            begin
                hbc_next = full ? 2'd0 : hbc_reg + 2'd1;
                acc_next = acc_new;
                if (full)
                begin
                    acc_next = '0;
                    if (acc_new > {20'd0, max_args})
                    begin
                        err = ST_MANY;
                    end
                    else
                    begin
                        args_rem_next = acc_new[11:0];
                        cur_arg_next  = '0;
                        phase_next    = PH_SIZE;
                    end
                end
            end
            PH_SIZE:
            begin
                if (args_rem_reg == 12'd0)
                begin
                    err = ST_TRAIL;
                end
                else
                begin
                    hbc_next = full ? 2'd0 : hbc_reg + 2'd1;
                    acc_next = acc_new;
                    if (full)
                    begin
                        acc_next = '0;
                        if (({18'd0, pos_reg} + 34'd1 + {2'd0, acc_new}) >
                            {18'd0, eff_len})
                        begin
                            err = ST_OVERRUN;
                        end
                        else if (acc_new == 32'd0)
                        begin
                            result.kind      = KIND_EMPTY;
                            result.arg_index = cur_arg_reg;
                            result.arg_last  = 1'b1;
                            args_rem_next    = args_rem_reg - 12'd1;
                            cur_arg_next     = cur_arg_reg + 12'd1;
                        end
                        else
                        begin
                            data_rem_next = acc_new[15:0];
                            phase_next    = PH_DATA;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                result.kind      = KIND_DATA;
                result.arg_byte  = item.data_byte;
                result.arg_index = cur_arg_reg;
                if (dr != 16'd0)
                begin
                    dr = dr - 16'd1;
                end
                data_rem_next = dr;
                if (dr == 16'd0)
                begin
                    result.arg_last = 1'b1;
                    args_rem_next   = args_rem_reg - 12'd1;
                    cur_arg_next    = cur_arg_reg + 12'd1;
                    phase_next      = PH_SIZE;
                end
            end
            PH_SKIP:
            begin
            end
            default:
            begin
            end
        endcase

        if (err != ST_BUSY)
        begin
            result.status = err;
            err_seen_next = 1'b1;
            phase_next    = PH_SKIP;
        end

        if (last)
        begin
            if (!err_seen_next)
            begin
                if (phase_next == PH_SIZE && args_rem_next == 12'd0 && hbc_next == 2'd0)
                begin
                    result.status = ST_OK;
                end
                else if (phase_next == PH_COUNT)
                begin
                    result.status = ST_SHORT;
                end
                else
                begin
                    result.status = ST_OVERRUN;
                end
            end
            phase_next    = PH_COUNT;
            pos_next      = '0;
            hbc_next      = '0;
            acc_next      = '0;
            args_rem_next = '0;
            data_rem_next = '0;
            cur_arg_next  = '0;
            err_seen_next = 1'b0;
        end
        else
        begin
            pos_next = pos_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_COUNT;
            pos_reg      <= '0;
            hbc_reg      <= '0;
            acc_reg      <= '0;
            args_rem_reg <= '0;
            data_rem_reg <= '0;
            cur_arg_reg  <= '0;
            err_seen_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            hbc_reg      <= hbc_next;
            acc_reg      <= acc_next;
            args_rem_reg <= args_rem_next;
            data_rem_reg <= data_rem_next;
            cur_arg_reg  <= cur_arg_next;
            err_seen_reg <= err_seen_next;
        end
    end

endmodule

// ----- design/lpad_out_stage.sv -----
// ----------------------------------------------------------------------------
// lpad_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module lpad_out_stage
    import lpad_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load_valid,
    input  out_item_t load_item,
    input  logic      out_stall,
    output logic      advance,
    output logic      out_valid,
    output out_item_t out_item
);

    logic      valid_reg;
    out_item_t item_reg;

    assign advance   = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= load_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_valid)
        begin
            item_reg <= load_item;
        end
    end

endmodule

// ----- design/length_prefixed_argument_deframer_core.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_argument_deframer_core
// Splits length-prefixed request frames into argument data bytes.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, in_item) takes one frame byte per item
// together with the frame length. Every input item yields exactly one result
// item on the output channel (out_valid, out_stall, out_item): a data byte, an
// empty-argument mark or a plain header byte, with frame_done on the final
// byte of each frame and the frame status there or on the byte with an error.
// An accepted item is held in the input register and then decoded into the
// result register, whose valid flag drives out_valid. Throughput is one item
// per cycle while the receiver does not stall, as the frame counters are
// updated once per item.
// When the receiver stalls, the result register holds its item and the stall
// reaches the input channel in the same cycle once the input register is full.
// The cfg channel (cfg_valid, cfg_ready, cfg_data) writes max_args; it is
// always ready and is meant to be written while the block is idle.
// Reset clears both registers' valid flags and the frame state, and sets
// max_args to 1024.
// ----------------------------------------------------------------------------
module length_prefixed_argument_deframer_core
    import lpad_pkg::*;
#(
    parameter int MAX_FRAME = 65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data
);

    logic        advance;
    logic        item_valid;
    in_item_t    item;
    out_item_t   result;
    logic [11:0] max_args_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_args_reg <= MAX_ARGS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_args_reg <= cfg_data;
        end
    end

    lpad_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_item    (in_item),
        .advance    (advance),
        .in_stall   (in_stall),
        .item_valid (item_valid),
        .item       (item)
    );

    lpad_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance && item_valid),
        .item     (item),
        .max_args (max_args_reg),
        .result   (result)
    );

    lpad_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (item_valid),
        .load_item  (result),
        .out_stall  (out_stall),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_item   (out_item)
    );

endmodule

// ----- design/lpad_checker.sv -----
// ----------------------------------------------------------------------------
// lpad_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module lpad_checker
    import lpad_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_item
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("Stalled result item changed.");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind == KIND_EMPTY |-> out_item.arg_last)
        else $error("Empty argument without last mark.");

    a_final_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.frame_done |->
            out_item.status != ST_OK && out_item.status != ST_SHORT)
        else $error("Frame status reported before the final byte.");

    a_header_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind == KIND_HDR |->
            out_item.arg_byte == 8'd0 && !out_item.arg_last && out_item.arg_index == 12'd0)
        else $error("Header byte carries argument fields.");

endmodule

bind length_prefixed_argument_deframer_core lpad_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
